/* rtl/core/psu_pkg.sv */
// Shared types and constants for the PNG scanline unfilter.
`timescale 1ns / 1ps

package psu_pkg;

  // Largest row width in pixels that the line store is sized for.
  localparam int unsigned PSU_MAX_ROW_PIXELS = 4096;

  // Configuration port geometry.
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Configuration register indexes.
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_COLOR_MODE = 2'd0,
    CFG_ROW_PIXELS = 2'd1,
    CFG_IMAGE_ROWS = 2'd2
  } cfg_idx_t;

  // Color modes; the unused code behaves as RGBA.
  typedef enum logic [1:0] {
    CM_INDEXED = 2'd0,
    CM_RGB     = 2'd1,
    CM_RGBA    = 2'd2
  } color_mode_t;

  // Row filter kinds after decoding the filter-type byte.
  typedef enum logic [2:0] {
    FLT_NONE  = 3'd0,
    FLT_SUB   = 3'd1,
    FLT_UP    = 3'd2,
    FLT_AVG   = 3'd3,
    FLT_PAETH = 3'd4,
    FLT_BAD   = 3'd5
  } filt_t;

  // Filter-type byte values defined by the format.
  localparam logic [7:0] FTYPE_NONE  = 8'd0;
  localparam logic [7:0] FTYPE_SUB   = 8'd1;
  localparam logic [7:0] FTYPE_UP    = 8'd2;
  localparam logic [7:0] FTYPE_AVG   = 8'd3;
  localparam logic [7:0] FTYPE_PAETH = 8'd4;

  function automatic filt_t decode_filter(input logic [7:0] ftype);
    filt_t f;
    case (ftype)
      FTYPE_NONE:  f = FLT_NONE;
      FTYPE_SUB:   f = FLT_SUB;
      FTYPE_UP:    f = FLT_UP;
      FTYPE_AVG:   f = FLT_AVG;
      FTYPE_PAETH: f = FLT_PAETH;
      default:     f = FLT_BAD;
    endcase
    return f;
  endfunction

  // Absolute difference of two 10-bit values.
  function automatic logic [9:0] abs_diff10(input logic [9:0] x, input logic [9:0] y);
    return (x > y) ? (x - y) : (y - x);
  endfunction

  // Paeth predictor: picks left, up or up-left, whichever is nearest a + b - c.
  function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
    logic [9:0] pa;
    logic [9:0] pb;
    logic [9:0] pc;
    logic [7:0] res;
    pa = abs_diff10({2'b00, b}, {2'b00, c});
    pb = abs_diff10({2'b00, a}, {2'b00, c});
    pc = abs_diff10(10'({2'b00, a}) + 10'({2'b00, b}), {1'b0, c, 1'b0});
    if ((pa <= pb) && (pa <= pc)) begin
      res = a;
    end else if (pb <= pc) begin
      res = b;
    end else begin
      res = c;
    end
    return res;
  endfunction

  // Control and payload of one sample between the line store read and the output.
  typedef struct packed {
    logic [7:0] raw;
    logic [1:0] lane;
    logic       has_left;
    logic       has_up;
    filt_t      filt;
    logic       row_end;
    logic       image_end;
  } s1_t;

endpackage

/* rtl/core/psu_in_if.sv */
// Input byte channel of the PNG scanline unfilter.
`timescale 1ns / 1ps

interface psu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] filtered_byte;

  modport source (output valid, output filtered_byte, input ready);
  modport sink   (input valid, input filtered_byte, output ready);
endinterface

/* rtl/core/psu_out_if.sv */
// Result channel of the PNG scanline unfilter.
`timescale 1ns / 1ps

interface psu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_byte;
  logic       row_end;
  logic       image_end;
  logic       bad_filter;

  modport source (output valid, output pixel_byte, output row_end, output image_end,
                  output bad_filter, input ready);
  modport sink   (input valid, input pixel_byte, input row_end, input image_end,
                  input bad_filter, output ready);
endinterface

/* rtl/core/png_scanline_unfilter.sv */
// Top level of the PNG scanline unfilter: filter reconstruction with a line store.
`timescale 1ns / 1ps

// Channel  Dir  Handshake     Payload
// in_ch    in   valid/ready   filtered_byte[7:0]
// out_ch   out  valid/ready   pixel_byte[7:0], row_end, image_end, bad_filter
// cfg_*    in   cfg_we only   cfg_addr[1:0] register index, cfg_wdata[15:0]
//
// One byte is taken per cycle, filter-type bytes included, as long as the result
// side keeps up. The line store read is issued when a sample byte transfers, with
// the sample entering the sample stage; the reconstructed byte lands in the output
// register as that stage advances. A registered line store read paces the pipeline.
// Reset (rst_n low at a clock edge) returns to the start of an image, awaiting a
// filter byte, with the reset register values; the line store is not cleared.
// A stalled output holds the sample stage, and then no input byte is taken.

module png_scanline_unfilter
  import psu_pkg::*;
#(
  parameter int unsigned MAX_ROW_PIXELS = PSU_MAX_ROW_PIXELS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  psu_in_if.sink                in_ch,
  psu_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // The line store holds one row at up to four bytes per pixel.
  localparam int unsigned STORE_DEPTH = MAX_ROW_PIXELS * 4;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
  // The byte column must also hold the full row length.
  localparam int unsigned COL_W       = $clog2(STORE_DEPTH + 1);

  // ---------------------------------------------------------------------------
  // Configuration registers.
  // ---------------------------------------------------------------------------
  logic [1:0]  color_mode_r;
  logic [12:0] row_pixels_r;
  logic [15:0] image_rows_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_mode_r <= CM_RGBA;
      row_pixels_r <= 13'(MAX_ROW_PIXELS);
      image_rows_r <= 16'd1;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_COLOR_MODE: color_mode_r <= cfg_wdata[1:0];
        CFG_ROW_PIXELS: row_pixels_r <= cfg_wdata[12:0];
        CFG_IMAGE_ROWS: image_rows_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // Bytes per pixel; the spare color mode code counts as RGBA.
  logic [2:0] bpp;
  always_comb begin
    case (color_mode_r)
      CM_INDEXED: bpp = 3'd1;
      CM_RGB:     bpp = 3'd3;
      default:    bpp = 3'd4;
    endcase
  end

  // Row length in bytes. A zero width counts as one pixel and widths above the
  // line store size saturate; times three is a shift and an add, four a shift.
  logic [31:0]      pix32;
  logic [31:0]      row_len32;
  logic [COL_W-1:0] row_len;
  logic [15:0]      rows;

  always_comb begin
    if (row_pixels_r == 13'd0) begin
      pix32 = 32'd1;
    end else if (32'(row_pixels_r) > 32'(MAX_ROW_PIXELS)) begin
      pix32 = 32'(MAX_ROW_PIXELS);
    end else begin
      pix32 = 32'(row_pixels_r);
    end
    case (color_mode_r)
      CM_INDEXED: row_len32 = pix32;
      CM_RGB:     row_len32 = pix32 + (pix32 << 1);
      default:    row_len32 = pix32 << 2;
    endcase
    row_len = row_len32[COL_W-1:0];
    rows    = (image_rows_r == 16'd0) ? 16'd1 : image_rows_r;
  end

  // ---------------------------------------------------------------------------
  // Stage 0: byte position tracking and the line store read.
  // ---------------------------------------------------------------------------
  logic             expect_filter_r, expect_filter_nxt;
  filt_t            row_filter_r, row_filter_nxt;
  logic [COL_W-1:0] byte_column_r, byte_column_nxt;
  logic [1:0]       mod3_r, mod3_nxt;       // byte_column modulo three
  logic [15:0]      row_index_r, row_index_nxt;

  logic             move;                   // the sample stage may advance
  logic             s1_valid_r;
  logic             in_ready;
  logic             acc;
  logic             acc_data;

  logic [COL_W-1:0] col_inc;
  logic             row_end;
  logic             image_end;
  logic [1:0]       lane;
  s1_t              s1_r, s1_nxt;
  logic [ADDR_W-1:0] s1_addr_r;

  assign move     = !out_ch.valid || out_ch.ready;
  assign in_ready = move || !s1_valid_r;
  assign acc      = in_ch.valid && in_ready;
  assign acc_data = acc && !expect_filter_r;
  assign in_ch.ready = in_ready;

  always_comb begin
    col_inc   = byte_column_r + COL_W'(1);
    row_end   = (col_inc >= row_len);
    image_end = row_end && ((17'(row_index_r) + 17'd1) >= 17'(rows));
    case (color_mode_r)
      CM_INDEXED: lane = 2'd0;
      CM_RGB:     lane = mod3_r;
      default:    lane = byte_column_r[1:0];
    endcase

    s1_nxt.raw       = in_ch.filtered_byte;
    s1_nxt.lane      = lane;
    s1_nxt.has_left  = (byte_column_r >= COL_W'(bpp));
    s1_nxt.has_up    = (row_index_r != 16'd0);
    s1_nxt.filt      = row_filter_r;
    s1_nxt.row_end   = row_end;
    s1_nxt.image_end = image_end;

    expect_filter_nxt = expect_filter_r;
    row_filter_nxt    = row_filter_r;
    byte_column_nxt   = byte_column_r;
    mod3_nxt          = mod3_r;
    row_index_nxt     = row_index_r;

    if (acc && expect_filter_r) begin
      // Filter-type byte: opens a row and yields no result.
      row_filter_nxt    = decode_filter(in_ch.filtered_byte);
      byte_column_nxt   = '0;
      mod3_nxt          = 2'd0;
      expect_filter_nxt = 1'b0;
    end else if (acc_data) begin
      if (row_end) begin
        expect_filter_nxt = 1'b1;
        byte_column_nxt   = '0;
        mod3_nxt          = 2'd0;
        row_index_nxt     = image_end ? 16'd0 : (row_index_r + 16'd1);
      end else begin
        byte_column_nxt = col_inc;
        mod3_nxt        = (mod3_r == 2'd2) ? 2'd0 : (mod3_r + 2'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_filter_r <= 1'b1;
      row_filter_r    <= FLT_NONE;
      byte_column_r   <= '0;
      mod3_r          <= 2'd0;
      row_index_r     <= 16'd0;
      s1_valid_r      <= 1'b0;
    end else begin
      expect_filter_r <= expect_filter_nxt;
      row_filter_r    <= row_filter_nxt;
      byte_column_r   <= byte_column_nxt;
      mod3_r          <= mod3_nxt;
      row_index_r     <= row_index_nxt;
      if (in_ready) begin
        s1_valid_r <= acc_data;
      end
    end
  end

  // Sample payload rides alongside the line store read.
  always_ff @(posedge clk) begin
    if (acc_data) begin
      s1_r      <= s1_nxt;
      s1_addr_r <= byte_column_r[ADDR_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Line store. Its read data holds while no new read is issued, so a stalled
  // sample keeps its up byte. A row's write lands before the next row's read of
  // the same column, since at least the filter byte separates them.
  // ---------------------------------------------------------------------------
  logic [7:0] up_rdata;
  logic [7:0] recon;
  logic       store_we;

  assign store_we = s1_valid_r && move;

  psu_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (s1_addr_r),
    .wdata (recon),
    .re    (acc_data),
    .raddr (byte_column_r[ADDR_W-1:0]),
    .rdata (up_rdata)
  );

  // ---------------------------------------------------------------------------
  // Stage 1: reconstruction. Left and up-left come from per-lane registers that
  // the previous pixel wrote; each is zero at the left edge and up is zero in
  // the first row.
  // ---------------------------------------------------------------------------
  logic [7:0] left_r   [4];
  logic [7:0] upleft_r [4];
  logic [7:0] a;
  logic [7:0] b;
  logic [7:0] c;
  logic [8:0] ab_sum;
  logic       bad;

  always_comb begin
    a      = s1_r.has_left ? left_r[s1_r.lane] : 8'd0;
    c      = s1_r.has_left ? upleft_r[s1_r.lane] : 8'd0;
    b      = s1_r.has_up ? up_rdata : 8'd0;
    ab_sum = {1'b0, a} + {1'b0, b};
    bad    = 1'b0;
    case (s1_r.filt)
      FLT_NONE:  recon = s1_r.raw;
      FLT_SUB:   recon = s1_r.raw + a;
      FLT_UP:    recon = s1_r.raw + b;
      FLT_AVG:   recon = s1_r.raw + ab_sum[8:1];
      FLT_PAETH: recon = s1_r.raw + paeth(a, b, c);
      default: begin
        // Unknown filter type: the raw byte passes and is flagged.
        recon = s1_r.raw;
        bad   = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        left_r[i]   <= 8'd0;
        upleft_r[i] <= 8'd0;
      end
    end else if (store_we) begin
      left_r[s1_r.lane]   <= recon;
      upleft_r[s1_r.lane] <= b;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register.
  // ---------------------------------------------------------------------------
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_row_end_r;
  logic       out_image_end_r;
  logic       out_bad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (move) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      out_byte_r      <= recon;
      out_row_end_r   <= s1_r.row_end;
      out_image_end_r <= s1_r.image_end;
      out_bad_r       <= bad;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.pixel_byte = out_byte_r;
  assign out_ch.row_end    = out_row_end_r;
  assign out_ch.image_end  = out_image_end_r;
  assign out_ch.bad_filter = out_bad_r;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !move) |=> (s1_valid_r && $stable(s1_r) && $stable(up_rdata)))
    else $error("sample stage changed while stalled");

  a_ready_only_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && out_valid_r))
    else $error("input refused with free pipeline space");

  a_row_end_reopens: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_data && row_end) |=> (expect_filter_r && (byte_column_r == '0)))
    else $error("row end did not return to awaiting a filter byte");

  a_image_end_in_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_r.image_end) |-> s1_r.row_end)
    else $error("image end flagged away from a row end");

  a_filter_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && expect_filter_r && !s1_valid_r) |=> !s1_valid_r)
    else $error("filter byte produced a sample");

endmodule

/* rtl/core/psu_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module psu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* verif/tb_png_scanline_unfilter.sv */
// Self-checking testbench for the PNG scanline unfilter with a byte-level scoreboard.
`timescale 1ns / 1ps

module tb_png_scanline_unfilter
  import psu_pkg::*;
;

  // Every column that the widest row can reach.
  localparam int unsigned LINE_STORE_DEPTH = PSU_MAX_ROW_PIXELS * 4;
  // Past this many mismatches only the count goes on.
  localparam int unsigned MAX_REPORTS = 100;

  typedef struct packed {
    logic [7:0] pixel_byte;
    logic       row_end;
    logic       image_end;
    logic       bad_filter;
  } pixel_result_t;

  class unfilter_scoreboard;
    logic [7:0]    line_store [LINE_STORE_DEPTH];
    logic [7:0]    left_px [4];
    logic [7:0]    upleft_px [4];
    logic [7:0]    row_ftype;
    int unsigned   column;
    int unsigned   row_num;
    bit            want_filter;
    logic [1:0]    color_mode;
    logic [12:0]   row_pixels;
    logic [15:0]   image_rows;
    pixel_result_t expected_q [$];
    int unsigned   errors;
    int unsigned   inputs_seen;
    int unsigned   results_seen;
    int unsigned   images_seen;
    int unsigned   rows_by_filter [6];

    function new();
      foreach (left_px[i]) begin
        left_px[i] = '0;
        upleft_px[i] = '0;
      end
      foreach (rows_by_filter[i]) rows_by_filter[i] = 0;
      row_ftype = '0;
      column = 0;
      row_num = 0;
      want_filter = 1'b1;
      color_mode = CM_RGBA;
      row_pixels = 13'(PSU_MAX_ROW_PIXELS);
      image_rows = 16'd1;
      errors = 0;
      inputs_seen = 0;
      results_seen = 0;
      images_seen = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_COLOR_MODE: color_mode = value[1:0];
        CFG_ROW_PIXELS: row_pixels = value[12:0];
        CFG_IMAGE_ROWS: image_rows = value[15:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Picks whichever neighbor lies nearest to left + up - upleft.
    function logic [7:0] paeth_pick(logic [7:0] a, logic [7:0] b, logic [7:0] c);
      int est;
      int da;
      int db;
      int dc;
      est = int'(a) + int'(b) - int'(c);
      da = est - int'(a);
      db = est - int'(b);
      dc = est - int'(c);
      if (da < 0) da = -da;
      if (db < 0) db = -db;
      if (dc < 0) dc = -dc;
      if (da <= db && da <= dc) return a;
      if (db <= dc) return b;
      return c;
    endfunction

    function void note_input(logic [7:0] raw);
      int unsigned   bpp;
      int unsigned   pix;
      int unsigned   rows;
      int unsigned   lane;
      logic [7:0]    a;
      logic [7:0]    b;
      logic [7:0]    c;
      pixel_result_t r;
      inputs_seen++;
      bpp = (color_mode == CM_INDEXED) ? 1 : (color_mode == CM_RGB) ? 3 : 4;
      pix = (row_pixels == 0) ? 1 :
            (row_pixels > PSU_MAX_ROW_PIXELS) ? PSU_MAX_ROW_PIXELS : row_pixels;
      rows = (image_rows == 0) ? 1 : image_rows;
      if (want_filter) begin
        row_ftype = raw;
        column = 0;
        want_filter = 1'b0;
        foreach (left_px[i]) begin
          left_px[i] = '0;
          upleft_px[i] = '0;
        end
        rows_by_filter[(raw > FTYPE_PAETH) ? int'(FTYPE_PAETH) + 1 : int'(raw)]++;
        return;
      end
      lane = column % bpp;
      b = (row_num > 0) ? line_store[column] : 8'h00;
      a = (column >= bpp) ? left_px[lane] : 8'h00;
      c = (column >= bpp) ? upleft_px[lane] : 8'h00;
      r.bad_filter = 1'b0;
      case (row_ftype)
        FTYPE_NONE:  r.pixel_byte = raw;
        FTYPE_SUB:   r.pixel_byte = raw + a;
        FTYPE_UP:    r.pixel_byte = raw + b;
        FTYPE_AVG:   r.pixel_byte = raw + 8'((int'(a) + int'(b)) / 2);
        FTYPE_PAETH: r.pixel_byte = raw + paeth_pick(a, b, c);
        default: begin
          r.pixel_byte = raw;
          r.bad_filter = 1'b1;
        end
      endcase
      left_px[lane] = r.pixel_byte;
      upleft_px[lane] = b;
      line_store[column] = r.pixel_byte;
      column++;
      r.row_end = (column >= pix * bpp);
      r.image_end = 1'b0;
      if (r.row_end) begin
        want_filter = 1'b1;
        column = 0;
        if (row_num + 1 >= rows) begin
          r.image_end = 1'b1;
          row_num = 0;
          images_seen++;
        end else begin
          row_num++;
        end
      end
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [7:0] pixel_byte, logic row_end, logic image_end,
                               logic bad_filter);
      pixel_result_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        if (errors < MAX_REPORTS) $error("unexpected result: pixel_byte %0d", pixel_byte);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (pixel_byte !== want.pixel_byte) begin
        if (errors < MAX_REPORTS)
          $error("pixel_byte: expected %0d, actual %0d", want.pixel_byte, pixel_byte);
        errors++;
      end
      if (row_end !== want.row_end) begin
        if (errors < MAX_REPORTS)
          $error("row_end: expected %0b, actual %0b", want.row_end, row_end);
        errors++;
      end
      if (image_end !== want.image_end) begin
        if (errors < MAX_REPORTS)
          $error("image_end: expected %0b, actual %0b", want.image_end, image_end);
        errors++;
      end
      if (bad_filter !== want.bad_filter) begin
        if (errors < MAX_REPORTS)
          $error("bad_filter: expected %0b, actual %0b", want.bad_filter, bad_filter);
        errors++;
      end
    endfunction
  endclass

  // A run is about 800 bytes. Even if each waited out both sides' longest idle gap
  // plus the pipeline, with all register writes, drains and the long hold-off, the
  // run stays several times below this limit.
  localparam int unsigned LIMIT_CYCLES = 200_000;
  // Length of the deliberate result-side hold-off, long enough to back up the input.
  localparam int unsigned HOLD_CYCLES = 300;
  // Cycles allowed after the last expected result for a filter byte still in flight.
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned RANDOM_ITEMS = 500;

  // The fourth color code has no name in the package; the block treats it as RGBA.
  localparam logic [1:0] CM_RGBA_ALIAS = 2'd3;
  // Filter-type bytes outside the format's range, lowest and highest.
  localparam logic [7:0] FTYPE_FIRST_BAD = 8'd5;
  localparam logic [7:0] FTYPE_LAST_BAD = 8'd255;
  // All-ones register values: row width saturates, row total is the largest.
  localparam logic [CFG_DATA_W-1:0] ROW_PIXELS_ALL_ONES = 16'h1FFF;
  localparam logic [CFG_DATA_W-1:0] IMAGE_ROWS_ALL_ONES = 16'hFFFF;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  psu_in_if  in_ch ();
  psu_out_if out_ch ();

  unfilter_scoreboard sb = new();

  // While quiet is set neither side idles, which gives back-to-back stretches.
  bit          quiet = 1'b0;
  // Set by the stimulus to ask the result side for one long hold-off.
  bit          hold_req = 1'b0;
  int unsigned cycle_count = 0;

  png_scanline_unfilter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycle_count, sb.pending());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Both channels are observed at the clock edge, before the block's own updates
  // land, so each transfer is seen exactly once and in order.
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) sb.note_input(in_ch.filtered_byte);
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.pixel_byte, out_ch.row_end, out_ch.image_end, out_ch.bad_filter);
  end

  // Each side idles before an item in about one case out of four.
  function automatic int unsigned pick_gap();
    if (quiet || $urandom_range(0, 3) != 0) return 0;
    return $urandom_range(1, 16);
  endfunction

  // Sample bytes lean toward the two extremes so that wraparound happens often.
  function automatic logic [7:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Offers one byte and returns at the edge where it transfers. Valid stays high so
  // that the next call can offer its byte without a bubble.
  task automatic send_byte(input logic [7:0] value);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.filtered_byte <= value;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // One row: the filter-type byte and then its samples.
  task automatic send_row(input logic [7:0] ftype, input int unsigned count);
    send_byte(ftype);
    repeat (count) send_byte(pick_sample());
  endtask

  // Stops offering and waits until every expected result has transferred.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Register writes happen only with the block idle. A filter byte produces no
  // result, so the wait goes on for SETTLE_CYCLES after the last result has come.
  task automatic set_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, value);
  endtask

  // Result side: per result it may idle for a while, and once on request it
  // holds off for a long stretch so that the block backs up into its input.
  initial begin : result_sink
    int unsigned gap;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      gap = pick_gap();
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  initial begin : stimulus
    logic [7:0]  dir_filters [6];
    logic [1:0]  cm;
    logic [7:0]  ftype;
    int unsigned px;
    int unsigned rows;
    int unsigned row_len;
    int unsigned random_items;

    in_ch.valid <= 1'b0;
    in_ch.filtered_byte <= 8'h00;
    cfg_we <= 1'b0;
    cfg_addr <= CFG_COLOR_MODE;
    cfg_wdata <= '0;
    rst_n <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values: RGBA, the widest row and a single row per image. The row runs
    // well past a short width, then the width shrinks below the count reached, so
    // the next sample ends both the row and the image.
    send_row(FTYPE_PAETH, 40);
    set_reg(CFG_ROW_PIXELS, 16'd8);
    send_byte(pick_sample());

    // Zero row width and zero row count both act as one: every image is one byte.
    // The highest invalid filter type passes its byte through flagged.
    set_reg(CFG_COLOR_MODE, 16'(CM_INDEXED));
    set_reg(CFG_ROW_PIXELS, 16'd0);
    set_reg(CFG_IMAGE_ROWS, 16'd0);
    send_byte(FTYPE_SUB);
    send_byte(8'hFF);
    send_byte(FTYPE_LAST_BAD);
    send_byte(8'h00);

    // Every filter in one image, with an invalid row right before an Up row so that
    // the raw bytes of the invalid row serve as the row above.
    dir_filters = '{FTYPE_NONE, FTYPE_SUB, FTYPE_FIRST_BAD, FTYPE_UP, FTYPE_AVG, FTYPE_PAETH};
    set_reg(CFG_ROW_PIXELS, 16'd2);
    set_reg(CFG_IMAGE_ROWS, 16'd6);
    foreach (dir_filters[i]) begin
      send_byte(dir_filters[i]);
      send_byte(8'hFF - 8'(i));
      send_byte(8'(i * 51));
    end

    // Registers changed while an image is under way. The row width shrinks below
    // the count already reached, so the next sample ends the row; then the row
    // total drops below the rows already done, so the next row ends the image.
    set_reg(CFG_ROW_PIXELS, 16'd4);
    set_reg(CFG_IMAGE_ROWS, IMAGE_ROWS_ALL_ONES);
    send_row(FTYPE_SUB, 4);
    send_row(FTYPE_UP, 3);
    set_reg(CFG_ROW_PIXELS, 16'd2);
    send_byte(8'h80);
    set_reg(CFG_IMAGE_ROWS, 16'd1);
    send_row(FTYPE_PAETH, 2);

    // The unnamed color code and an all-ones row width, which saturates to the
    // line store size. The first row is cut short by a narrower width, and the
    // second row reads the row above across that whole width.
    set_reg(CFG_COLOR_MODE, 16'(CM_RGBA_ALIAS));
    set_reg(CFG_ROW_PIXELS, ROW_PIXELS_ALL_ONES);
    set_reg(CFG_IMAGE_ROWS, 16'd2);
    send_row(FTYPE_SUB, 48);
    set_reg(CFG_ROW_PIXELS, 16'd12);
    send_byte(pick_sample());
    send_row(FTYPE_PAETH, 48);

    // Back pressure: the result side holds off while bytes keep coming back to back,
    // so the block fills and stops taking input. The sender then waits for it all.
    set_reg(CFG_COLOR_MODE, 16'(CM_RGB));
    set_reg(CFG_ROW_PIXELS, 16'd40);
    set_reg(CFG_IMAGE_ROWS, 16'd1);
    quiet = 1'b1;
    hold_req = 1'b1;
    send_row(FTYPE_AVG, 120);
    quiet = 1'b0;
    drain();

    // Random images: mostly narrow rows in any color mode, now and then a wider one,
    // about one row in ten with an invalid filter type.
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      cm = 2'($urandom_range(0, 3));
      case ($urandom_range(0, 7))
        0: px = 0;
        1: px = $urandom_range(7, 40);
        default: px = $urandom_range(1, 6);
      endcase
      rows = $urandom_range(0, 4);
      set_reg(CFG_COLOR_MODE, 16'(cm));
      set_reg(CFG_ROW_PIXELS, 16'(px));
      set_reg(CFG_IMAGE_ROWS, 16'(rows));
      quiet = ($urandom_range(0, 5) == 0);
      row_len = ((px == 0) ? 1 : px) * ((cm == CM_INDEXED) ? 1 : (cm == CM_RGB) ? 3 : 4);
      repeat ((rows == 0) ? 1 : rows) begin
        if ($urandom_range(0, 9) == 0)
          ftype = 8'($urandom_range(FTYPE_FIRST_BAD, FTYPE_LAST_BAD));
        else
          ftype = 8'($urandom_range(FTYPE_NONE, FTYPE_PAETH));
        send_row(ftype, row_len);
        random_items += row_len + 1;
        if ($urandom_range(0, 9) == 0) drain();
      end
    end
    quiet = 1'b0;

    // Everything offered has transferred; wait out the results and a little more
    // so that any stray extra result would still be caught.
    drain();
    repeat (4 * SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d input transfers and %0d result transfers in %0d images.",
             sb.inputs_seen, sb.results_seen, sb.images_seen);
    $display("Rows by filter type: none %0d, sub %0d, up %0d, average %0d, paeth %0d, %s",
             sb.rows_by_filter[0], sb.rows_by_filter[1], sb.rows_by_filter[2],
             sb.rows_by_filter[3], sb.rows_by_filter[4],
             $sformatf("invalid %0d; %0d failures.", sb.rows_by_filter[5], sb.errors));
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/psu_pkg.sv
rtl/core/psu_in_if.sv
rtl/core/psu_out_if.sv
rtl/core/psu_ram.sv
rtl/core/png_scanline_unfilter.sv
verif/tb_png_scanline_unfilter.sv
